// File: rtl/core/sdspi_pkg.sv
// Package: phase codes, flag bits, status codes and item types for the SD SPI sequencer
package sdspi_pkg;

  typedef enum logic [4:0] {
    PH_IDLE, PH_WAKE, PH_CMD0, PH_CMD58A, PH_CMD8, PH_CMD55, PH_ACMD41,
    PH_CMD58B, PH_CMD1, PH_CMD16, PH_CMD17, PH_RDTOKEN, PH_RDDATA, PH_CMD24,
    PH_WRPAD, PH_WRTOKEN, PH_WRDATA, PH_WRRESP, PH_WRBUSY, PH_RELEASE
  } phase_t;

  localparam logic [1:0] CMD_INIT = 2'd0;
  localparam logic [1:0] CMD_READ = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_XFER = 2'd3;

  localparam logic [1:0] CFG_TOKEN_WAIT = 2'd0;
  localparam logic [1:0] CFG_OP_TRIES = 2'd1;
  localparam logic [1:0] CFG_WAKE = 2'd2;
  localparam logic [1:0] CFG_WR_PAD = 2'd3;

  localparam logic [3:0] FL_PRESENT = 4'h1;
  localparam logic [3:0] FL_HD = 4'h2;
  localparam logic [3:0] FL_SDHC = 4'h4;
  localparam logic [3:0] FL_INIT = 4'h8;

  localparam logic [3:0] ST_OK = 4'd0;
  localparam logic [3:0] ST_IDLE_TO = 4'd1;
  localparam logic [3:0] ST_OCR_FAIL = 4'd2;
  localparam logic [3:0] ST_BAD_VOLT = 4'd3;
  localparam logic [3:0] ST_BAD_PAT = 4'd4;
  localparam logic [3:0] ST_OPCOND_TO = 4'd5;
  localparam logic [3:0] ST_BLKLEN = 4'd6;
  localparam logic [3:0] ST_NOT_INIT = 4'd7;
  localparam logic [3:0] ST_RD_FAIL = 4'd8;
  localparam logic [3:0] ST_WR_REJ = 4'd10;

  localparam logic [1:0] MODE_OFF = 2'd0;
  localparam logic [1:0] MODE_SLOW = 2'd1;
  localparam logic [1:0] MODE_FAST = 2'd2;

  localparam logic [9:0] TOKEN_POS = 10'd7;
  localparam logic [9:0] OCR_END = 10'd12;
  localparam logic [9:0] SECTOR_BYTES = 10'd512;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] sector;
    logic [7:0]  rx_byte;
    logic [7:0]  wr_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       card_select;
    logic [1:0] spi_mode;
    logic [7:0] rd_data;
    logic       rd_valid;
    logic       wr_taken;
    logic       op_done;
    logic [3:0] status;
    logic [7:0] card_response;
    logic [3:0] card_flags;
  } out_item_t;

  typedef struct packed {
    logic [15:0] token_wait_limit;
    logic [15:0] op_cond_tries;
    logic [7:0]  wake_bytes;
    logic [7:0]  write_pad_bytes;
  } cfg_t;

  // Command index of the frame sent in a phase
  function automatic logic [5:0] cmd_index(input phase_t p);
    unique case (p)
      PH_CMD58A, PH_CMD58B: cmd_index = 6'd58;
      PH_CMD8:   cmd_index = 6'd8;
      PH_CMD55:  cmd_index = 6'd55;
      PH_ACMD41: cmd_index = 6'd41;
      PH_CMD1:   cmd_index = 6'd1;
      PH_CMD16:  cmd_index = 6'd16;
      PH_CMD17:  cmd_index = 6'd17;
      PH_CMD24:  cmd_index = 6'd24;
      default:   cmd_index = 6'd0;
    endcase
  endfunction

  // Byte k of a command frame: lead 0xFF, index, argument, CRC
  function automatic logic [7:0] frame_byte(input phase_t p, input logic [9:0] k,
                                            input logic [31:0] addr);
    logic [31:0] arg;
    logic [5:0]  idx;
    idx = cmd_index(p);
    arg = 32'd0;
    if (p == PH_CMD8) arg = 32'h0000_01AA;
    else if (p == PH_ACMD41) arg = 32'h4000_0000;
    else if (p == PH_CMD16) arg = 32'd512;
    else if (p == PH_CMD17 || p == PH_CMD24) arg = addr;
    if (k == 10'd0) frame_byte = 8'hFF;
    else if (k == 10'd1) frame_byte = {2'b01, idx};
    else if (k <= 10'd5) begin
      unique case (k[2:0])
        3'd2:    frame_byte = arg[31:24];
        3'd3:    frame_byte = arg[23:16];
        3'd4:    frame_byte = arg[15:8];
        default: frame_byte = arg[7:0];
      endcase
    end else if (idx == 6'd0) frame_byte = 8'h95;
    else if (idx == 6'd8) frame_byte = 8'h87;
    else frame_byte = 8'hFF;
  endfunction

endpackage

// File: rtl/core/sdspi_if.sv
// Interfaces: valid/ready request channels and the configuration write channel
interface sdspi_in_if import sdspi_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sdspi_out_if import sdspi_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sdspi_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

// File: rtl/core/sdspi_cfg_regs.sv
// Configuration register file of the SD SPI sequencer
module sdspi_cfg_regs import sdspi_pkg::*; (
  input  logic clk,
  input  logic rst,
  sdspi_cfg_if.sink cfg,
  output cfg_t regs
);

  assign cfg.ready = 1'b1;

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.token_wait_limit <= 16'd16383;
      regs.op_cond_tries <= 16'd32767;
      regs.wake_bytes <= 8'd10;
      regs.write_pad_bytes <= 8'd16;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_TOKEN_WAIT: regs.token_wait_limit <= cfg.wdata;
        CFG_OP_TRIES:   regs.op_cond_tries <= cfg.wdata;
        CFG_WAKE:       regs.wake_bytes <= cfg.wdata[7:0];
        default:        regs.write_pad_bytes <= cfg.wdata[7:0];
      endcase
    end
  end

endmodule

// File: rtl/core/sdspi_engine.sv
// Sequencer state and per-byte next-state logic
module sdspi_engine import sdspi_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      regs,
  input  logic      step,
  input  in_item_t  item,
  output out_item_t res
);

  phase_t      phase, phase_next;
  logic [3:0]  flags, flags_next;
  logic [9:0]  byte_count, byte_count_next;
  logic [15:0] wait_count, wait_count_next;
  logic [15:0] retry_count, retry_count_next;
  logic [31:0] ocr_bytes, ocr_bytes_next;
  logic [31:0] card_address, card_address_next;
  logic [7:0]  last_response, last_response_next;
  logic        cs_on, cs_on_next;
  logic [1:0]  clk_mode, clk_mode_next;
  logic [3:0]  end_status, end_status_next;
  logic [7:0]  end_resp, end_resp_next;

  // Next-state and result logic for one exchange
  always_comb begin
    logic [7:0]  rx;
    logic [7:0]  r;
    logic        do_decide;
    logic        do_got;
    logic        do_finish;
    logic [3:0]  fin_st;
    logic [7:0]  fin_resp;
    logic        do_enter;
    phase_t      enter_p;
    logic        do_try;
    phase_t      try_p;
    logic [15:0] wdec;
    logic [9:0]  bc1;
    rx = item.rx_byte;
    r = 8'hFF;
    do_decide = 1'b0; do_got = 1'b0; do_finish = 1'b0; do_enter = 1'b0; do_try = 1'b0;
    fin_st = ST_OK; fin_resp = 8'd0; enter_p = PH_IDLE; try_p = PH_IDLE;
    wdec = wait_count - 16'd1;
    bc1 = byte_count + 10'd1;

    phase_next = phase; flags_next = flags; byte_count_next = byte_count;
    wait_count_next = wait_count; retry_count_next = retry_count;
    ocr_bytes_next = ocr_bytes; card_address_next = card_address;
    last_response_next = last_response; cs_on_next = cs_on; clk_mode_next = clk_mode;
    end_status_next = end_status; end_resp_next = end_resp;
    res = '0;

    if (item.cmd == CMD_XFER) begin
      if (phase != PH_IDLE) begin
        unique case (phase)
          PH_WAKE: begin
            wait_count_next = wdec;
            if (wdec == 16'd0) begin
              do_enter = 1'b1; enter_p = PH_CMD0;
            end else begin
              res.tx_valid = 1'b1; res.tx_byte = 8'hFF;
            end
          end
          PH_RDTOKEN: begin
            if (rx != 8'hFF) begin
              if (rx != 8'hFE) begin
                do_finish = 1'b1; fin_st = ST_RD_FAIL;
              end else begin
                phase_next = PH_RDDATA; byte_count_next = 10'd0;
                res.tx_valid = 1'b1; res.tx_byte = 8'hFF;
              end
            end else begin
              wait_count_next = wdec;
              if (wdec == 16'd0) begin
                do_finish = 1'b1; fin_st = ST_RD_FAIL;
              end else begin
                res.tx_valid = 1'b1; res.tx_byte = 8'hFF;
              end
            end
          end
          PH_RDDATA: begin
            if (byte_count < SECTOR_BYTES) begin
              res.rd_data = rx; res.rd_valid = 1'b1;
            end
            byte_count_next = bc1;
            if (bc1 >= SECTOR_BYTES + 10'd2) do_finish = 1'b1;
            else begin
              res.tx_valid = 1'b1; res.tx_byte = 8'hFF;
            end
          end
          PH_WRPAD: begin
            wait_count_next = wdec;
            res.tx_valid = 1'b1;
            if (wdec == 16'd0) begin
              phase_next = PH_WRTOKEN; res.tx_byte = 8'hFE;
            end else res.tx_byte = 8'hFF;
          end
          PH_WRTOKEN: begin
            phase_next = PH_WRDATA; byte_count_next = 10'd0;
            res.tx_valid = 1'b1; res.tx_byte = item.wr_byte; res.wr_taken = 1'b1;
          end
          PH_WRDATA: begin
            byte_count_next = bc1;
            res.tx_valid = 1'b1;
            if (bc1 < SECTOR_BYTES) begin
              res.tx_byte = item.wr_byte; res.wr_taken = 1'b1;
            end else begin
              res.tx_byte = 8'hFF;
              if (bc1 >= SECTOR_BYTES + 10'd2) phase_next = PH_WRRESP;
            end
          end
          PH_WRRESP: begin
            res.tx_valid = 1'b1; res.tx_byte = 8'hFF;
            if (rx != 8'hFF) begin
              if (rx == 8'hE5) begin
                end_status_next = ST_OK; end_resp_next = 8'd0;
              end else begin
                end_status_next = ST_WR_REJ; end_resp_next = rx;
              end
              phase_next = PH_WRBUSY;
            end
          end
          PH_WRBUSY: begin
            if (rx == 8'd0) begin
              res.tx_valid = 1'b1; res.tx_byte = 8'hFF;
            end else begin
              do_finish = 1'b1; fin_st = end_status; fin_resp = end_resp;
            end
          end
          PH_RELEASE: begin
            phase_next = PH_IDLE; cs_on_next = 1'b0; clk_mode_next = MODE_OFF;
            res.op_done = 1'b1; res.status = end_status; res.card_response = end_resp;
          end
          default: begin
            // Command frame, response poll and trailing R3/R7 bytes
            if (byte_count < TOKEN_POS) begin
              byte_count_next = bc1;
              if (bc1 < TOKEN_POS) begin
                res.tx_valid = 1'b1; res.tx_byte = frame_byte(phase, bc1, card_address);
              end else if (phase == PH_CMD24) begin
                res.tx_valid = 1'b1;
                if (regs.write_pad_bytes == 8'd0) begin
                  phase_next = PH_WRTOKEN; res.tx_byte = 8'hFE;
                end else begin
                  phase_next = PH_WRPAD; res.tx_byte = 8'hFF;
                  wait_count_next = {8'd0, regs.write_pad_bytes};
                end
              end else if (regs.token_wait_limit == 16'd0) begin
                do_got = 1'b1; r = 8'hFF;
              end else begin
                wait_count_next = regs.token_wait_limit;
                res.tx_valid = 1'b1; res.tx_byte = 8'hFF;
              end
            end else if (byte_count == TOKEN_POS) begin
              if (rx != 8'hFF) begin
                do_got = 1'b1; r = rx;
              end else begin
                wait_count_next = wdec;
                if (wdec == 16'd0) begin
                  do_got = 1'b1; r = 8'hFF;
                end else begin
                  res.tx_valid = 1'b1; res.tx_byte = 8'hFF;
                end
              end
            end else begin
              ocr_bytes_next = {ocr_bytes[23:0], rx};
              byte_count_next = bc1;
              if (bc1 >= OCR_END) begin
                do_decide = 1'b1; r = last_response;
              end else begin
                res.tx_valid = 1'b1; res.tx_byte = 8'hFF;
              end
            end
          end
        endcase
      end
    end else if (phase == PH_IDLE) begin
      if (item.cmd == CMD_INIT) begin
        flags_next = 4'd0; clk_mode_next = MODE_SLOW; cs_on_next = 1'b0;
        if (regs.wake_bytes == 8'd0) begin
          do_enter = 1'b1; enter_p = PH_CMD0;
        end else begin
          phase_next = PH_WAKE; wait_count_next = {8'd0, regs.wake_bytes};
          res.tx_valid = 1'b1; res.tx_byte = 8'hFF;
        end
      end else if ((flags & FL_INIT) == 4'd0) begin
        res.op_done = 1'b1; res.status = ST_NOT_INIT;
      end else begin
        card_address_next = ((flags & FL_HD) != 4'd0) ? item.sector
                                                       : {item.sector[22:0], 9'd0};
        clk_mode_next = MODE_FAST;
        do_enter = 1'b1;
        enter_p = (item.cmd == CMD_READ) ? PH_CMD17 : PH_CMD24;
      end
    end

    // Response arrived: R3/R7 collect four more bytes, else decide now
    if (do_got) begin
      last_response_next = r;
      if (phase == PH_CMD58A || phase == PH_CMD8 || phase == PH_CMD58B) begin
        byte_count_next = TOKEN_POS + 10'd1; ocr_bytes_next = 32'd0;
        res.tx_valid = 1'b1; res.tx_byte = 8'hFF;
      end else do_decide = 1'b1;
    end

    // Act on the response of the command in flight
    if (do_decide) begin
      unique case (phase)
        PH_CMD0: begin
          if (r != 8'd1) begin
            do_finish = 1'b1; fin_st = ST_IDLE_TO;
          end else begin
            flags_next = flags_next | FL_PRESENT; clk_mode_next = MODE_FAST;
            do_enter = 1'b1; enter_p = PH_CMD58A;
          end
        end
        PH_CMD58A: begin
          if (r != 8'd1) begin
            do_finish = 1'b1; fin_st = ST_OCR_FAIL;
          end else if (ocr_bytes_next[20] == 1'b0) begin
            do_finish = 1'b1; fin_st = ST_BAD_VOLT;
          end else begin
            do_enter = 1'b1; enter_p = PH_CMD8;
          end
        end
        PH_CMD8: begin
          retry_count_next = regs.op_cond_tries;
          if (r == 8'd1) begin
            flags_next = flags_next | FL_SDHC;
            if (ocr_bytes_next[11:8] != 4'd1) begin
              do_finish = 1'b1; fin_st = ST_BAD_VOLT;
            end else if (ocr_bytes_next[7:0] != 8'hAA) begin
              do_finish = 1'b1; fin_st = ST_BAD_PAT;
            end else begin
              do_try = 1'b1; try_p = PH_CMD55;
            end
          end else begin
            do_try = 1'b1; try_p = PH_CMD1;
          end
        end
        PH_CMD55: begin
          do_enter = 1'b1; enter_p = PH_ACMD41;
        end
        PH_ACMD41: begin
          if (r == 8'd0) begin
            do_enter = 1'b1; enter_p = PH_CMD58B;
          end else begin
            do_try = 1'b1; try_p = PH_CMD55;
          end
        end
        PH_CMD58B: begin
          if (r != 8'd0) begin
            do_finish = 1'b1; fin_st = ST_OCR_FAIL;
          end else begin
            if (ocr_bytes_next[30:29] == 2'b10) flags_next = flags_next | FL_HD;
            do_enter = 1'b1; enter_p = PH_CMD16;
          end
        end
        PH_CMD1: begin
          if (r[0] == 1'b0) begin
            do_enter = 1'b1; enter_p = PH_CMD16;
          end else begin
            do_try = 1'b1; try_p = PH_CMD1;
          end
        end
        PH_CMD16: begin
          do_finish = 1'b1;
          if (r != 8'd0) fin_st = ST_BLKLEN;
          else flags_next = flags_next | FL_INIT;
        end
        default: begin
          if (r != 8'd0 || regs.token_wait_limit == 16'd0) begin
            do_finish = 1'b1; fin_st = ST_RD_FAIL;
          end else begin
            phase_next = PH_RDTOKEN; wait_count_next = regs.token_wait_limit;
            res.tx_valid = 1'b1; res.tx_byte = 8'hFF;
          end
        end
      endcase
    end

    // Retry loop bound
    if (do_try) begin
      if (retry_count_next == 16'd0) begin
        do_finish = 1'b1; fin_st = ST_OPCOND_TO;
      end else begin
        retry_count_next = retry_count_next - 16'd1;
        do_enter = 1'b1; enter_p = try_p;
      end
    end

    if (do_enter) begin
      phase_next = enter_p; byte_count_next = 10'd0; cs_on_next = 1'b1;
      res.tx_valid = 1'b1; res.tx_byte = 8'hFF;
    end

    if (do_finish) begin
      end_status_next = fin_st; end_resp_next = fin_resp;
      phase_next = PH_RELEASE; cs_on_next = 1'b0;
      res.tx_valid = 1'b1; res.tx_byte = 8'hFF;
    end

    res.card_select = cs_on_next;
    res.spi_mode = clk_mode_next;
    res.card_flags = flags_next;
  end

  // Advance state on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE; flags <= 4'd0; byte_count <= 10'd0; wait_count <= 16'd0;
      retry_count <= 16'd0; ocr_bytes <= 32'd0; card_address <= 32'd0;
      last_response <= 8'hFF; cs_on <= 1'b0; clk_mode <= MODE_OFF;
      end_status <= ST_OK; end_resp <= 8'd0;
    end else if (step) begin
      phase <= phase_next; flags <= flags_next; byte_count <= byte_count_next;
      wait_count <= wait_count_next; retry_count <= retry_count_next;
      ocr_bytes <= ocr_bytes_next; card_address <= card_address_next;
      last_response <= last_response_next; cs_on <= cs_on_next;
      clk_mode <= clk_mode_next; end_status <= end_status_next;
      end_resp <= end_resp_next;
    end
  end

  // Chip select is never held while idle
  a_idle_cs: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> !cs_on) else $error("chip select held while idle");
  // Release byte always goes out deselected
  a_rel_cs: assert property (@(posedge clk) disable iff (rst)
    phase == PH_RELEASE |-> !cs_on) else $error("release with select asserted");
  // Data byte count stays inside the sector and CRC window
  a_rd_cnt: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_RDDATA || phase == PH_WRDATA) |-> byte_count < SECTOR_BYTES + 10'd2)
    else $error("data byte count overrun");

endmodule

// File: rtl/core/sd_card_spi_host_sequencer.sv
// Top level: SD card SPI-mode host sequencer with registered request channels
// Use: the host sends one request per SPI byte exchange on "in": cmd 0, 1 or 2
// starts init, sector read or sector write; cmd 3 reports the byte received in
// the exchange just completed. Each request yields exactly one result on "out"
// naming the next byte to shift (tx_byte/tx_valid), chip select, clock mode,
// any sector data byte received, wr_taken when wr_byte was consumed, and
// op_done with the final status at the end of an operation.
// Configuration registers are written on "cfg" (index 0 to 3); the host must do
// so only while idle, as the block does not enforce it. A result is presented in
// the cycle after its request is accepted. Throughput: one request per cycle when
// not stalled; the sequencer state update is a single pass into the result register.
// Stall: "in" stays ready while the result register is empty or being taken
// in the same cycle; when the receiver holds off, the result is held and no
// further request is taken.
// Reset (rst, synchronous): sequencer idle, card flags cleared, registers at
// their defaults, result register empty.
module sd_card_spi_host_sequencer import sdspi_pkg::*; (
  input logic clk,
  input logic rst,
  sdspi_in_if.sink   in,
  sdspi_out_if.source out,
  sdspi_cfg_if.sink  cfg
);

  cfg_t      regs;
  out_item_t res;
  logic      step;
  logic      out_valid;
  out_item_t out_data;

  sdspi_cfg_regs u_cfg (.clk(clk), .rst(rst), .cfg(cfg), .regs(regs));

  assign in.ready = !out_valid || out.ready;
  assign step = in.valid && in.ready;

  sdspi_engine u_eng (
    .clk(clk), .rst(rst), .regs(regs), .step(step), .item(in.data), .res(res)
  );

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (step) out_valid <= 1'b1;
    else if (out.ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (step) out_data <= res;
  end

  assign out.valid = out_valid;
  assign out.data = out_data;

  // A stalled result is not overwritten
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out.ready |=> $stable(out_data)) else $error("result overwritten");
  // No request is taken while a stalled result waits
  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out.ready |-> !step) else $error("request taken under stall");
  // Every accepted request leaves a result pending
  a_res: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid) else $error("result lost");

endmodule
